[design/crp_pkg.sv]
// Shared types, status codes and control structures of the conjugate root pairing block.
`default_nettype none
package crp_pkg;

	typedef struct packed {
		logic        kind;
		logic [31:0] prime;
		logic [31:0] root;
		logic        side;
		logic [31:0] entry_index;
	} crp_in_t;

	typedef struct packed {
		logic [31:0] source_index;
		logic [31:0] target_index;
		logic [1:0]  status;
		logic        last;
	} crp_out_t;

	localparam logic [1:0] ST_PAIRED = 2'd0;
	localparam logic [1:0] ST_ODD    = 2'd1;
	localparam logic [1:0] ST_NOCONJ = 2'd2;
	localparam logic [1:0] ST_OVF    = 2'd3;

	typedef enum logic [1:0] {
		RD_K  = 2'd0,
		RD_K1 = 2'd1,
		RD_L  = 2'd2,
		RD_J  = 2'd3
	} crp_rd_sel_t;

	typedef struct packed {
		logic        latch_in;
		logic        append;
		logic        clr_group;
		logic        k_clr;
		logic        k_inc2;
		logic        l_init;
		logic        l_inc;
		logic        j_clr;
		logic        j_inc;
		logic        rd_en;
		crp_rd_sel_t rd_sel;
		logic        wr_l;
		logic        wr_k1;
		logic        inv_special;
		logic        div_go;
		logic        div_eu;
		logic        eu_load;
		logic        mul;
		logic        eu_upd;
		logic        inv_fin;
		logic        ii_l_cap;
		logic        mode_set;
		logic [1:0]  mode;
		logic        emit_load;
	} crp_cmd_t;

	typedef struct packed {
		logic pend_kind;
		logic same_group;
		logic grp_nonempty;
		logic ovf;
		logic n_odd;
		logic r_zero;
		logic r_p;
		logic p_lt2;
		logic div_done;
		logic a_zero;
		logic cur_r_zero;
		logic old_r_one;
		logic l_end;
		logic match;
		logic k_last;
		logic j_last;
		logic out_free;
	} crp_stat_t;

endpackage
`default_nettype wire

[design/crp_div.sv]
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
`default_nettype none
module crp_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quot,
	output logic [31:0]      rem
);
	logic [31:0] acc_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic        fits;

	assign shifted = {acc_q, quo_q[31]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				acc_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				acc_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = acc_q;
endmodule
`default_nettype wire

[design/crp_datapath.sv]
// Datapath: group buffers, inverse arithmetic, search counters and the result register.
`default_nettype none
module crp_datapath import crp_pkg::*; #(
	parameter int MAX_ROOTS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire crp_cmd_t cmd,
	input  wire crp_in_t  item,
	input  wire logic     result_ready,
	output crp_stat_t     stat,
	output logic          result_valid,
	output crp_out_t      result
);
	localparam int AW = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;
	localparam int CW = $clog2(MAX_ROOTS + 1);

	logic [31:0] rr_mem [MAX_ROOTS];
	logic [31:0] ii_mem [MAX_ROOTS];
	logic [31:0] oi_mem [MAX_ROOTS];

	crp_in_t     pend_q;
	logic [31:0] gp_q;
	logic        gs_q;
	logic [CW-1:0] count_q;
	logic        ovf_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] l_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] k1;
	logic [CW-1:0] k2;
	logic [31:0] rd_rr_q;
	logic [31:0] rd_ii_q;
	logic [31:0] rd_oi_q;
	logic [31:0] inv_q;
	logic [31:0] ii_l_q;
	logic [31:0] rep_q;
	logic [1:0]  mode_q;
	logic [31:0] old_r_q;
	logic [31:0] cur_r_q;
	logic [33:0] old_s_q;
	logic [33:0] cur_s_q;
	logic [33:0] prod_q;
	logic [33:0] s_pos;
	logic [33:0] s_fin;
	logic        out_valid_q;
	crp_out_t    out_q;

	logic          wr_en;
	logic          wr_oi;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_rr;
	logic [31:0]   wr_ii;
	logic [AW-1:0] rd_addr;
	logic          start_grp;

	logic        div_done;
	logic [31:0] div_q;
	logic [31:0] div_r;
	logic [31:0] div_a;
	logic [31:0] div_b;

	assign k1 = k_q + CW'(1);
	assign k2 = k_q + CW'(2);
	assign start_grp = cmd.clr_group && !pend_q.kind && (pend_q.prime != 32'd0);

	assign div_a = cmd.div_eu ? old_r_q : rd_rr_q;
	assign div_b = cmd.div_eu ? cur_r_q : gp_q;

	crp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);

	always_comb begin
		wr_en   = 1'b0;
		wr_oi   = 1'b0;
		wr_addr = '0;
		wr_rr   = pend_q.root;
		wr_ii   = pend_q.entry_index;
		if (cmd.append && (count_q < CW'(MAX_ROOTS))) begin
			wr_en   = 1'b1;
			wr_oi   = 1'b1;
			wr_addr = count_q[AW-1:0];
		end else if (start_grp) begin
			wr_en   = 1'b1;
			wr_oi   = 1'b1;
		end else if (cmd.wr_l) begin
			wr_en   = 1'b1;
			wr_addr = l_q[AW-1:0];
			wr_rr   = rd_rr_q;
			wr_ii   = rd_ii_q;
		end else if (cmd.wr_k1) begin
			wr_en   = 1'b1;
			wr_addr = k1[AW-1:0];
			wr_rr   = inv_q;
			wr_ii   = ii_l_q;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_K:    rd_addr = k_q[AW-1:0];
			RD_K1:   rd_addr = k1[AW-1:0];
			RD_L:    rd_addr = l_q[AW-1:0];
			RD_J:    rd_addr = j_q[AW-1:0];
			default: rd_addr = k_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rr_mem[wr_addr] <= wr_rr;
			ii_mem[wr_addr] <= wr_ii;
		end
		if (wr_en && wr_oi) begin
			oi_mem[wr_addr] <= wr_ii;
		end
		if (cmd.rd_en) begin
			rd_rr_q <= rr_mem[rd_addr];
			rd_ii_q <= ii_mem[rd_addr];
			rd_oi_q <= oi_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q    <= '0;
			gs_q    <= 1'b0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.append) begin
			if (count_q < CW'(MAX_ROOTS)) begin
				count_q <= count_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end else if (start_grp) begin
			gp_q    <= pend_q.prime;
			gs_q    <= pend_q.side;
			count_q <= CW'(1);
			ovf_q   <= 1'b0;
		end else if (cmd.clr_group) begin
			gp_q    <= '0;
			gs_q    <= 1'b0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			l_q    <= '0;
			j_q    <= '0;
			mode_q <= ST_PAIRED;
		end else begin
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.k_inc2) begin
				k_q <= k2;
			end
			if (cmd.l_init) begin
				l_q <= k1;
			end else if (cmd.l_inc) begin
				l_q <= l_q + CW'(1);
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + CW'(1);
			end
			if (cmd.mode_set) begin
				mode_q <= cmd.mode;
			end
		end
	end

	assign s_pos = old_s_q[33] ? (old_s_q + {2'b00, gp_q}) : old_s_q;
	assign s_fin = (s_pos >= {2'b00, gp_q}) ? (s_pos - {2'b00, gp_q}) : s_pos;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			pend_q <= item;
		end
		if (cmd.inv_special) begin
			inv_q <= (rd_rr_q == 32'd0) ? gp_q : 32'd0;
		end else if (cmd.inv_fin) begin
			inv_q <= s_fin[31:0];
		end
		if (cmd.ii_l_cap) begin
			ii_l_q <= rd_ii_q;
		end
		if (cmd.eu_load) begin
			old_r_q <= div_r;
			cur_r_q <= gp_q;
			old_s_q <= 34'd1;
			cur_s_q <= '0;
		end else if (cmd.eu_upd) begin
			old_r_q <= cur_r_q;
			cur_r_q <= div_r;
			old_s_q <= cur_s_q;
			cur_s_q <= old_s_q - prod_q;
		end
		if (cmd.mul) begin
			prod_q <= {2'b00, div_q} * cur_s_q;
		end
		if (cmd.emit_load && !j_q[0]) begin
			rep_q <= rd_ii_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_q.status <= mode_q;
			out_q.last   <= (j_q == count_q - CW'(1));
			if (mode_q == ST_PAIRED) begin
				out_q.source_index <= rd_ii_q;
				out_q.target_index <= j_q[0] ? rep_q : rd_ii_q;
			end else begin
				out_q.source_index <= rd_oi_q;
				out_q.target_index <= rd_oi_q;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign stat.pend_kind    = pend_q.kind;
	assign stat.same_group   = (gp_q != 32'd0) && (pend_q.prime == gp_q) &&
	                           (pend_q.side == gs_q);
	assign stat.grp_nonempty = (gp_q != 32'd0) && (count_q != '0);
	assign stat.ovf          = ovf_q;
	assign stat.n_odd        = count_q[0];
	assign stat.r_zero       = (rd_rr_q == 32'd0);
	assign stat.r_p          = (rd_rr_q == gp_q);
	assign stat.p_lt2        = (gp_q < 32'd2);
	assign stat.div_done     = div_done;
	assign stat.a_zero       = (div_r == 32'd0);
	assign stat.cur_r_zero   = (cur_r_q == 32'd0);
	assign stat.old_r_one    = (old_r_q == 32'd1);
	assign stat.l_end        = (l_q >= count_q);
	assign stat.match        = (rd_rr_q == inv_q);
	assign stat.k_last       = (k2 >= count_q);
	assign stat.j_last       = (j_q == count_q - CW'(1));
	assign stat.out_free     = !out_valid_q || result_ready;
endmodule
`default_nettype wire

[design/crp_ctrl.sv]
// Controller state machine sequencing gathering, inverse search, swaps and emission.
`default_nettype none
module crp_ctrl import crp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	input  wire crp_stat_t stat,
	output logic           item_ready,
	output crp_cmd_t       cmd
);
	typedef enum logic [17:0] {
		S_IDLE      = 18'b000000000000000001,
		S_CHECK     = 18'b000000000000000010,
		S_WALK_RD   = 18'b000000000000000100,
		S_INV_START = 18'b000000000000001000,
		S_INV_RED   = 18'b000000000000010000,
		S_EU_CHK    = 18'b000000000000100000,
		S_EU_DIV    = 18'b000000000001000000,
		S_EU_MUL    = 18'b000000000010000000,
		S_EU_UPD    = 18'b000000000100000000,
		S_EU_FIN    = 18'b000000001000000000,
		S_SRCH_RD   = 18'b000000010000000000,
		S_SRCH_CMP  = 18'b000000100000000000,
		S_SWAP_RD   = 18'b000001000000000000,
		S_SWAP_W1   = 18'b000010000000000000,
		S_SWAP_W2   = 18'b000100000000000000,
		S_EMIT_RD   = 18'b001000000000000000,
		S_EMIT_OUT  = 18'b010000000000000000,
		S_START     = 18'b100000000000000000
	} crp_state_t;

	crp_state_t state_q;
	crp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.rd_sel = RD_K;
		cmd.mode   = ST_PAIRED;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.latch_in = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!stat.pend_kind && stat.same_group) begin
					cmd.append = 1'b1;
					state_d = S_IDLE;
				end else if (stat.grp_nonempty) begin
					cmd.j_clr = 1'b1;
					if (stat.ovf) begin
						cmd.mode_set = 1'b1;
						cmd.mode = ST_OVF;
						state_d = S_EMIT_RD;
					end else if (stat.n_odd) begin
						cmd.mode_set = 1'b1;
						cmd.mode = ST_ODD;
						state_d = S_EMIT_RD;
					end else begin
						cmd.k_clr = 1'b1;
						state_d = S_WALK_RD;
					end
				end else begin
					state_d = S_START;
				end
			end
			S_WALK_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_K;
				state_d = S_INV_START;
			end
			S_INV_START: begin
				if (stat.r_zero || stat.r_p) begin
					cmd.inv_special = 1'b1;
					cmd.l_init = 1'b1;
					state_d = S_SRCH_RD;
				end else if (stat.p_lt2) begin
					cmd.mode_set = 1'b1;
					cmd.mode = ST_NOCONJ;
					cmd.j_clr = 1'b1;
					state_d = S_EMIT_RD;
				end else begin
					cmd.div_go = 1'b1;
					state_d = S_INV_RED;
				end
			end
			S_INV_RED: begin
				if (stat.div_done) begin
					if (stat.a_zero) begin
						cmd.mode_set = 1'b1;
						cmd.mode = ST_NOCONJ;
						cmd.j_clr = 1'b1;
						state_d = S_EMIT_RD;
					end else begin
						cmd.eu_load = 1'b1;
						state_d = S_EU_CHK;
					end
				end
			end
			S_EU_CHK: begin
				if (stat.cur_r_zero) begin
					state_d = S_EU_FIN;
				end else begin
					cmd.div_go = 1'b1;
					cmd.div_eu = 1'b1;
					state_d = S_EU_DIV;
				end
			end
			S_EU_DIV: begin
				if (stat.div_done) begin
					state_d = S_EU_MUL;
				end
			end
			S_EU_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_EU_UPD;
			end
			S_EU_UPD: begin
				cmd.eu_upd = 1'b1;
				state_d = S_EU_CHK;
			end
			S_EU_FIN: begin
				if (stat.old_r_one) begin
					cmd.inv_fin = 1'b1;
					cmd.l_init = 1'b1;
					state_d = S_SRCH_RD;
				end else begin
					cmd.mode_set = 1'b1;
					cmd.mode = ST_NOCONJ;
					cmd.j_clr = 1'b1;
					state_d = S_EMIT_RD;
				end
			end
			S_SRCH_RD: begin
				if (stat.l_end) begin
					cmd.mode_set = 1'b1;
					cmd.mode = ST_NOCONJ;
					cmd.j_clr = 1'b1;
					state_d = S_EMIT_RD;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_L;
					state_d = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (stat.match) begin
					cmd.ii_l_cap = 1'b1;
					state_d = S_SWAP_RD;
				end else begin
					cmd.l_inc = 1'b1;
					state_d = S_SRCH_RD;
				end
			end
			S_SWAP_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_K1;
				state_d = S_SWAP_W1;
			end
			S_SWAP_W1: begin
				cmd.wr_l = 1'b1;
				state_d = S_SWAP_W2;
			end
			S_SWAP_W2: begin
				cmd.wr_k1 = 1'b1;
				if (stat.k_last) begin
					cmd.mode_set = 1'b1;
					cmd.mode = ST_PAIRED;
					cmd.j_clr = 1'b1;
					state_d = S_EMIT_RD;
				end else begin
					cmd.k_inc2 = 1'b1;
					state_d = S_WALK_RD;
				end
			end
			S_EMIT_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_J;
				state_d = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				if (stat.out_free) begin
					cmd.emit_load = 1'b1;
					if (stat.j_last) begin
						state_d = S_START;
					end else begin
						cmd.j_inc = 1'b1;
						state_d = S_EMIT_RD;
					end
				end
			end
			S_START: begin
				cmd.clr_group = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

[design/conjugate_root_pairing_top.sv]
// Top level of the conjugate root pairing block.
// Input words carry ideal entries (kind 0) or a flush marker (kind 1) on a
// valid/ready channel; result words leave on a second valid/ready channel.
// Entries of the same prime and side are gathered into a group of up to
// MAX_ROOTS members; an entry that joins the group produces no result. An
// entry of another prime or side, or a flush word, closes the group and emits
// one result word per member, last set on the final one.
// Even groups are paired with a modular inverse found by extended Euclid on a
// one-bit-per-cycle divider, followed by a linear buffer search for each
// inverse; the divider sets the latency, one item in flight at a time.
// Reset clears the group state and the result valid flag; buffer contents are
// undefined until written. When the receiver stalls, the held result word
// stays stable and the block waits; a new word is taken only once the
// previous one has produced all its results.
`default_nettype none
module conjugate_root_pairing_top import crp_pkg::*; #(
	parameter int MAX_ROOTS = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire crp_in_t item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output crp_out_t     result
);
	crp_cmd_t  cmd;
	crp_stat_t stat;

	crp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.stat       (stat),
		.item_ready (item_ready),
		.cmd        (cmd)
	);

	crp_datapath #(
		.MAX_ROOTS (MAX_ROOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.result_ready (result_ready),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);
endmodule
`default_nettype wire

[verif/conjugate_root_pairing_top_test.sv]
// Self-checking testbench for the conjugate root pairing block.
`timescale 1ns / 1ps
module conjugate_root_pairing_top_test;
	import crp_pkg::*;

	localparam int MAXR = 16;
	localparam int WATCHDOG_LIMIT = 400000;

	class pairing_board;
		logic [31:0] g_prime;
		logic g_side;
		int g_count;
		logic g_ovf;
		logic [31:0] g_roots[MAXR];
		logic [31:0] g_idx[MAXR];
		crp_out_t pending_maps[$];
		int errors;

		function new();
			g_prime = 0;
			g_side = 0;
			g_count = 0;
			g_ovf = 0;
			errors = 0;
		endfunction

		function bit mod_inverse(logic [31:0] r, logic [31:0] p,
				output logic [31:0] inv);
			longint unsigned m, a, o_r, c_r, o_s, c_s, q, t, nr, ns;
			inv = 0;
			if (r == 0) begin
				inv = p;
				return 1;
			end
			if (r == p) begin
				inv = 0;
				return 1;
			end
			if (p < 2) return 0;
			m = p;
			a = r % m;
			if (a == 0) return 0;
			o_r = a;
			c_r = m;
			o_s = 1;
			c_s = 0;
			while (c_r != 0) begin
				q = o_r / c_r;
				nr = o_r - q * c_r;
				t = ((q % m) * c_s) % m;
				ns = (o_s + m - t) % m;
				o_r = c_r;
				c_r = nr;
				o_s = c_s;
				c_s = ns;
			end
			if (o_r != 1) return 0;
			inv = 32'(o_s % m);
			return 1;
		endfunction

		function void push_map(logic [31:0] s, logic [31:0] t, logic [1:0] st);
			crp_out_t w;
			w.source_index = s;
			w.target_index = t;
			w.status = st;
			w.last = 0;
			pending_maps.push_back(w);
		endfunction

		function void close_group();
			int n, k, l;
			bit ok;
			logic [31:0] rr[MAXR], ii[MAXR], inv, tmp;
			crp_out_t w;
			n = g_count;
			if (g_prime != 0 && n != 0) begin
				if (g_ovf || n[0]) begin
					for (k = 0; k < n; k++)
						push_map(g_idx[k], g_idx[k], g_ovf ? ST_OVF : ST_ODD);
				end else begin
					ok = 1;
					for (k = 0; k < n; k++) begin
						rr[k] = g_roots[k];
						ii[k] = g_idx[k];
					end
					for (k = 0; k < n && ok; k += 2) begin
						if (!mod_inverse(rr[k], g_prime, inv)) begin
							ok = 0;
							break;
						end
						for (l = k + 1; l < n; l++)
							if (rr[l] == inv) break;
						if (l >= n) begin
							ok = 0;
							break;
						end
						rr[l] = rr[k + 1];
						rr[k + 1] = inv;
						tmp = ii[l];
						ii[l] = ii[k + 1];
						ii[k + 1] = tmp;
					end
					for (k = 0; k < n; k++)
						if (!ok) push_map(g_idx[k], g_idx[k], ST_NOCONJ);
						else push_map(ii[k], ii[k & ~1], ST_PAIRED);
				end
				w = pending_maps.pop_back();
				w.last = 1;
				pending_maps.push_back(w);
			end
			g_prime = 0;
			g_side = 0;
			g_count = 0;
			g_ovf = 0;
		endfunction

		function void note_word(crp_in_t x);
			if (x.kind) begin
				close_group();
				return;
			end
			if (g_prime != 0 && x.prime == g_prime && x.side == g_side) begin
				if (g_count < MAXR) begin
					g_roots[g_count] = x.root;
					g_idx[g_count] = x.entry_index;
					g_count++;
				end else g_ovf = 1;
				return;
			end
			close_group();
			if (x.prime != 0) begin
				g_prime = x.prime;
				g_side = x.side;
				g_roots[0] = x.root;
				g_idx[0] = x.entry_index;
				g_count = 1;
			end
		endfunction

		task check_map(crp_out_t got);
			crp_out_t w;
			if (pending_maps.size() == 0) begin
				report_mismatch($sformatf("unexpected result src=%h", got.source_index));
				return;
			end
			w = pending_maps.pop_front();
			if (got.source_index !== w.source_index)
				report_mismatch($sformatf("source %h exp %h", got.source_index, w.source_index));
			if (got.target_index !== w.target_index)
				report_mismatch($sformatf("target %h exp %h", got.target_index, w.target_index));
			if (got.status !== w.status)
				report_mismatch($sformatf("status %0d exp %0d", got.status, w.status));
			if (got.last !== w.last)
				report_mismatch($sformatf("last %0d exp %0d", got.last, w.last));
		endtask

		task report_mismatch(string msg);
			errors++;
			$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_ready;
	crp_in_t item = '0;
	logic result_valid;
	logic result_ready = 0;
	crp_out_t result;

	pairing_board board = new();
	bit hold_results = 0;
	int idle_cycles = 0;
	int rx_wait = 0;
	int items_sent = 0;

	conjugate_root_pairing_top #(.MAX_ROOTS(MAXR)) dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready) board.note_word(item);
		if (arst_n && result_valid && result_ready) board.check_map(result);
		if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || hold_results) begin
			result_ready <= 0;
		end else if (result_valid && result_ready) begin
			rx_wait = $urandom_range(0, 14);
			result_ready <= (rx_wait == 0);
		end else if (rx_wait > 0) begin
			rx_wait = rx_wait - 1;
			result_ready <= (rx_wait == 0);
		end else begin
			result_ready <= 1;
		end
	end

	task automatic send_word(logic kind, logic [31:0] p, logic [31:0] r, logic s,
			logic [31:0] idx, bit gaps);
		int g;
		g = gaps ? $urandom_range(0, 14) : 0;
		if (g > 0) begin
			item_valid <= 0;
			repeat (g) @(posedge clk);
		end
		item_valid <= 1;
		item.kind <= kind;
		item.prime <= p;
		item.root <= r;
		item.side <= s;
		item.entry_index <= idx;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic release_input();
		item_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_entry(logic [31:0] p, logic [31:0] r, logic s, bit gaps);
		send_word(0, p, r, s, $urandom, gaps);
	endtask

	// Sends an even group: roots in conjugate pairs, shuffled, with one root sometimes corrupted.
	task automatic send_paired_group(logic [31:0] p, logic s, int pairs, bit gaps);
		logic [31:0] rs[$];
		logic [31:0] r, inv;
		int k;
		for (k = 0; k < pairs; k++) begin
			case ($urandom_range(0, 3))
				0: r = 0;
				1: r = p;
				default: r = $urandom_range(1, p - 1);
			endcase
			void'(board.mod_inverse(r, p, inv));
			rs.push_back(r);
			rs.push_back(inv);
		end
		rs.shuffle();
		if ($urandom_range(0, 9) == 0) rs[0] = rs[0] ^ 32'h1;
		foreach (rs[j]) send_entry(p, rs[j], s, gaps);
	endtask

	task automatic wait_drained();
		while (board.pending_maps.size() != 0) @(posedge clk);
	endtask

	logic [31:0] primes[8] = '{32'd2, 32'd3, 32'd5, 32'd7, 32'd101, 32'd65521,
		32'd2147483647, 32'd4294967291};

	initial begin
		int k, n;
		logic [31:0] p;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_word(1, 0, 0, 0, 0, 0);
		send_entry(7, 3, 0, 0);
		send_entry(7, 5, 0, 0);
		send_entry(7, 0, 1, 0);
		send_entry(7, 7, 1, 0);
		send_entry(7, 9, 1, 0);
		send_entry(7, 4, 1, 0);
		send_entry(0, 1, 0, 0);
		send_entry(32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0);
		send_entry(32'hFFFFFFFF, 32'h0, 1, 0);
		send_entry(32'd4294967291, 32'hFFFFFFFF, 0, 0);
		send_word(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 0);
		send_entry(5, 1, 0, 0);
		send_entry(5, 2, 0, 0);
		send_entry(5, 4, 0, 0);
		for (k = 0; k < 18; k++) send_entry(3, k % 3, 1, 0);
		send_word(1, 0, 0, 0, 0, 0);
		release_input();
		wait_drained();
		fork
			begin
				hold_results = 1;
				repeat (400) @(posedge clk);
				hold_results = 0;
			end
			begin
				for (k = 0; k < 6; k++) send_paired_group(101, k[0], 1, 0);
				release_input();
			end
		join
		wait_drained();
		while (items_sent < 196) begin
			p = primes[$urandom_range(0, 7)];
			n = $urandom_range(0, 9);
			if (n < 6) send_paired_group(p, 1'($urandom_range(0, 1)), $urandom_range(1, 4), 1);
			else if (n < 8) begin
				for (k = $urandom_range(1, 5); k > 0; k--)
					send_entry(p, $urandom, 1'($urandom_range(0, 1)), 1);
			end else if (n == 8) send_word(1'($urandom), $urandom, $urandom, 1'($urandom),
				$urandom, 1);
			else send_entry(0, $urandom, 1'($urandom_range(0, 1)), 1);
			if ($urandom_range(0, 15) == 0) begin
				release_input();
				wait_drained();
			end
		end
		send_word(1, 0, 0, 0, 0, 0);
		release_input();
		wait_drained();
		repeat (2000) @(posedge clk);
		if (board.errors == 0 && board.pending_maps.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

[conjugate_root_pairing_top.f]
design/crp_pkg.sv
design/crp_div.sv
design/crp_datapath.sv
design/crp_ctrl.sv
design/conjugate_root_pairing_top.sv
verif/conjugate_root_pairing_top_test.sv
